// ===== rtl/ffa_pkg.sv =====
// Shared types and fixed field widths for the first-fit free-list allocator.
`default_nettype none
package ffa_pkg;

  // Fixed field widths of the request and response beats
  localparam int REQ_W   = 16;
  localparam int ADDR_W  = 16;
  localparam int SIZE_W  = 17;
  localparam int LIMIT_W = 17;

  localparam logic [LIMIT_W-1:0] HEAP_LIMIT_RST = 17'h10000;

  // Request modes
  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  // Response status codes
  localparam logic STATUS_DONE = 1'b0;
  localparam logic STATUS_OOM  = 1'b1;

  // Shared adder operations
  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } ffa_alu_op_t;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_NEED,
    ST_FLOOR,
    ST_SCAN,
    ST_GADDR,
    ST_LSUM,
    ST_LCHK,
    ST_CARVE,
    ST_FLOW,
    ST_FHDR,
    ST_FRANGE,
    ST_FTEST,
    ST_FPUSH,
    ST_DONE
  } ffa_state_t;

endpackage
`default_nettype wire

// ===== rtl/ffa_req_if.sv =====
// Request channel: valid/ready handshake with allocate or free payload.
`default_nettype none
interface ffa_req_if import ffa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              mode;
  logic [REQ_W-1:0]  request_size;
  logic [ADDR_W-1:0] free_addr;

  modport source (output valid, output mode, output request_size, output free_addr,
                  input ready);
  modport sink   (input valid, input mode, input request_size, input free_addr,
                  output ready);
endinterface
`default_nettype wire

// ===== rtl/ffa_rsp_if.sv =====
// Response channel: valid/ready handshake with grant result payload.
`default_nettype none
interface ffa_rsp_if import ffa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] addr;
  logic              status;
  logic              reused;
  logic [SIZE_W-1:0] block_bytes;

  modport source (output valid, output addr, output status, output reused,
                  output block_bytes, input ready);
  modport sink   (input valid, input addr, input status, input reused,
                  input block_bytes, output ready);
endinterface
`default_nettype wire

// ===== rtl/first_fit_free_list_allocator_core.sv =====
// First-fit free-list heap allocator: top level with sequencer and block tables.
//
// Usage: in_req carries one beat per request (mode 0 allocate request_size
// bytes, mode 1 free free_addr). out_rsp returns exactly one beat per request:
// payload address, status (out of memory), whether the block was reused from
// the free list, and the granted block size including its header.
// cfg_we/cfg_wdata write the heap limit; write it only while the block is idle.
// Timing: in_req.ready is high only when the sequencer is idle; one request is
// worked at a time through a single shared adder. Allocate sizes the request,
// then scans the free list one entry per cycle, set by the table read port,
// and either reuses the first entry that fits, carves a new block at the
// break, or reports out of memory past the limit. Free checks the address,
// then, if it is valid and allocated, marks the block free and pushes it at
// the list head. After the result is loaded the sequencer returns to idle.
// Reset: the break returns to the end of the sentinel block, the free list
// empties and the limit returns to its full value. Block tables are not
// cleared; no clearing pass is needed.
// Stall: the result sits in an output register; while out_rsp.ready is low a held
// result waits there and a finished request holds the sequencer in its final state.
`default_nettype none
module first_fit_free_list_allocator_core import ffa_pkg::*; #(
  parameter int HEAP_BYTES      = 65536,
  parameter int ALIGN_BYTES     = 8,
  parameter int MIN_BLOCK_BYTES = 24
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  ffa_req_if.sink                 in_req,
  ffa_rsp_if.source               out_rsp,
  input  wire logic               cfg_we,
  input  wire logic [LIMIT_W-1:0] cfg_wdata
);

  localparam int SLOTS  = HEAP_BYTES / ALIGN_BYTES;
  localparam int IDX_W  = $clog2(SLOTS);
  localparam int SH     = $clog2(ALIGN_BYTES);
  localparam int BRK_W  = $clog2(HEAP_BYTES) + 1;
  localparam int AW     = ((BRK_W > SIZE_W) ? BRK_W : SIZE_W) + 1;
  localparam int HDR    = ((8 + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
  localparam int MINBLK = ((MIN_BLOCK_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
  localparam int STEP_W = IDX_W + 1;

  ffa_state_t state_r, state_nxt;

  logic [REQ_W-1:0]   req_r, req_nxt;
  logic [ADDR_W-1:0]  fa_r, fa_nxt;
  logic [AW-1:0]      need_r, need_nxt;
  logic [AW-1:0]      sum_r, sum_nxt;
  logic [IDX_W-1:0]   cur_r, cur_nxt;
  logic [STEP_W-1:0]  steps_r, steps_nxt;
  logic [BRK_W-1:0]   brk_r, brk_nxt;
  logic [LIMIT_W-1:0] lim_r, lim_nxt;
  logic [IDX_W-1:0]   first_r, first_nxt;
  logic [IDX_W-1:0]   last_r, last_nxt;

  logic [ADDR_W-1:0]  res_addr_r, res_addr_nxt;
  logic               res_status_r, res_status_nxt;
  logic               res_reused_r, res_reused_nxt;
  logic [SIZE_W-1:0]  res_bytes_r, res_bytes_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [ADDR_W-1:0]  out_addr_r;
  logic               out_status_r;
  logic               out_reused_r;
  logic [SIZE_W-1:0]  out_bytes_r;
  logic               out_load;

  // Shared adder
  ffa_alu_op_t        alu_op;
  logic [AW-1:0]      alu_a, alu_b, alu_res;
  logic               alu_ge;

  // Block tables: size, forward link, backward link
  logic [IDX_W-1:0]   rd_addr;
  logic               size_we, next_we, prev_we;
  logic [IDX_W-1:0]   size_waddr, next_waddr, prev_waddr;
  logic [SIZE_W-1:0]  size_wdata, size_rd;
  logic [IDX_W-1:0]   next_wdata, prev_wdata, next_rd, prev_rd;

  logic [SIZE_W-1:0]  sz_clean;
  logic [AW-1:0]      lim_eff;
  logic [IDX_W-1:0]   hdr_idx;
  logic               accept;

  ffa_alu #(.WIDTH(AW)) u_alu (
    .op  (alu_op),
    .a   (alu_a),
    .b   (alu_b),
    .res (alu_res),
    .ge  (alu_ge)
  );

  ffa_ram #(.WIDTH(SIZE_W), .DEPTH(SLOTS)) u_size_ram (
    .clk   (clk),
    .we    (size_we),
    .waddr (size_waddr),
    .wdata (size_wdata),
    .raddr (rd_addr),
    .rdata (size_rd)
  );

  ffa_ram #(.WIDTH(IDX_W), .DEPTH(SLOTS)) u_next_ram (
    .clk   (clk),
    .we    (next_we),
    .waddr (next_waddr),
    .wdata (next_wdata),
    .raddr (rd_addr),
    .rdata (next_rd)
  );

  ffa_ram #(.WIDTH(IDX_W), .DEPTH(SLOTS)) u_prev_ram (
    .clk   (clk),
    .we    (prev_we),
    .waddr (prev_waddr),
    .wdata (prev_wdata),
    .raddr (rd_addr),
    .rdata (prev_rd)
  );

  assign accept   = in_req.valid && in_req.ready;
  assign sz_clean = {size_rd[SIZE_W-1:1], 1'b0};
  assign hdr_idx  = sum_r[SH +: IDX_W];
  assign lim_eff  = (AW'(lim_r) < AW'(HEAP_BYTES)) ? AW'(lim_r) : AW'(HEAP_BYTES);
  assign out_load = (state_r == ST_DONE) && (!out_valid_r || out_rsp.ready);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = (in_req.mode == MODE_FREE) ? ST_FLOW : ST_NEED;
        end
      end
      ST_NEED:  state_nxt = ST_FLOOR;
      ST_FLOOR: state_nxt = (first_r != '0) ? ST_SCAN : ST_LSUM;
      ST_SCAN: begin
        if (alu_ge) begin
          state_nxt = ST_GADDR;
        end else if (next_rd == '0 || (steps_r + 1'b1) == STEP_W'(SLOTS)) begin
          state_nxt = ST_LSUM;
        end
      end
      ST_GADDR:  state_nxt = ST_DONE;
      ST_LSUM:   state_nxt = ST_LCHK;
      ST_LCHK:   state_nxt = alu_ge ? ST_CARVE : ST_DONE;
      ST_CARVE:  state_nxt = ST_DONE;
      ST_FLOW:   state_nxt = alu_ge ? ST_FHDR : ST_DONE;
      ST_FHDR:   state_nxt = ST_FRANGE;
      ST_FRANGE: begin
        state_nxt = (!alu_ge && sum_r[SH-1:0] == '0) ? ST_FTEST : ST_DONE;
      end
      ST_FTEST:  state_nxt = size_rd[0] ? ST_FPUSH : ST_DONE;
      ST_FPUSH:  state_nxt = ST_DONE;
      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Datapath controls and register updates per state
  always_comb begin
    req_nxt        = req_r;
    fa_nxt         = fa_r;
    need_nxt       = need_r;
    sum_nxt        = sum_r;
    cur_nxt        = cur_r;
    steps_nxt      = steps_r;
    brk_nxt        = brk_r;
    first_nxt      = first_r;
    last_nxt       = last_r;
    res_addr_nxt   = res_addr_r;
    res_status_nxt = res_status_r;
    res_reused_nxt = res_reused_r;
    res_bytes_nxt  = res_bytes_r;
    alu_op         = ALU_ADD;
    alu_a          = '0;
    alu_b          = '0;
    rd_addr        = '0;
    size_we        = 1'b0;
    size_waddr     = cur_r;
    size_wdata     = '0;
    next_we        = 1'b0;
    next_waddr     = cur_r;
    next_wdata     = '0;
    prev_we        = 1'b0;
    prev_waddr     = cur_r;
    prev_wdata     = '0;

    case (state_r)
      // Capture the request beat
      ST_IDLE: begin
        if (accept) begin
          req_nxt = in_req.request_size;
          fa_nxt  = in_req.free_addr;
        end
      end
      // Round size plus header up to the alignment
      ST_NEED: begin
        alu_a    = AW'(req_r);
        alu_b    = AW'(HDR + ALIGN_BYTES - 1);
        need_nxt = alu_res & ~AW'(ALIGN_BYTES - 1);
      end
      // Apply the minimum block floor and start reading the list head
      ST_FLOOR: begin
        alu_op    = ALU_SUB;
        alu_a     = need_r;
        alu_b     = AW'(MINBLK);
        if (!alu_ge) begin
          need_nxt = AW'(MINBLK);
        end
        cur_nxt   = first_r;
        steps_nxt = '0;
        rd_addr   = first_r;
      end
      // Test one list entry per cycle; unlink it on a fit
      ST_SCAN: begin
        alu_op = ALU_SUB;
        alu_a  = AW'(sz_clean);
        alu_b  = need_r;
        if (alu_ge) begin
          size_we        = 1'b1;
          size_waddr     = cur_r;
          size_wdata     = sz_clean | SIZE_W'(1);
          if (prev_rd != '0) begin
            next_we    = 1'b1;
            next_waddr = prev_rd;
            next_wdata = next_rd;
          end else begin
            first_nxt  = next_rd;
          end
          if (next_rd != '0) begin
            prev_we    = 1'b1;
            prev_waddr = next_rd;
            prev_wdata = prev_rd;
          end else begin
            last_nxt   = prev_rd;
          end
          res_status_nxt = STATUS_DONE;
          res_reused_nxt = 1'b1;
          res_bytes_nxt  = sz_clean;
        end else begin
          steps_nxt = steps_r + 1'b1;
          cur_nxt   = next_rd;
          rd_addr   = next_rd;
        end
      end
      // Payload address of the reused block
      ST_GADDR: begin
        alu_a        = AW'({cur_r, {SH{1'b0}}});
        alu_b        = AW'(HDR);
        res_addr_nxt = alu_res[ADDR_W-1:0];
      end
      // End of the new block at the break
      ST_LSUM: begin
        alu_a   = AW'(brk_r);
        alu_b   = need_r;
        sum_nxt = alu_res;
      end
      // Limit check; fail without state change when it runs past
      ST_LCHK: begin
        alu_op = ALU_SUB;
        alu_a  = lim_eff;
        alu_b  = sum_r;
        if (!alu_ge) begin
          res_addr_nxt   = '0;
          res_status_nxt = STATUS_OOM;
          res_reused_nxt = 1'b0;
          res_bytes_nxt  = '0;
        end
      end
      // Carve at the break and advance it
      ST_CARVE: begin
        alu_a          = AW'(brk_r);
        alu_b          = AW'(HDR);
        size_we        = 1'b1;
        size_waddr     = brk_r[SH +: IDX_W];
        size_wdata     = need_r[SIZE_W-1:0] | SIZE_W'(1);
        brk_nxt        = sum_r[BRK_W-1:0];
        res_addr_nxt   = alu_res[ADDR_W-1:0];
        res_status_nxt = STATUS_DONE;
        res_reused_nxt = 1'b0;
        res_bytes_nxt  = need_r[SIZE_W-1:0];
      end
      // Free: drop null and addresses below the first real block
      ST_FLOW: begin
        alu_op         = ALU_SUB;
        alu_a          = AW'(fa_r);
        alu_b          = AW'(HDR + MINBLK);
        res_addr_nxt   = '0;
        res_status_nxt = STATUS_DONE;
        res_reused_nxt = 1'b0;
        res_bytes_nxt  = '0;
      end
      // Header offset of the freed block
      ST_FHDR: begin
        alu_op  = ALU_SUB;
        alu_a   = AW'(fa_r);
        alu_b   = AW'(HDR);
        sum_nxt = alu_res;
      end
      // Header must be aligned and lie below the break; read its size entry
      ST_FRANGE: begin
        alu_op  = ALU_SUB;
        alu_a   = sum_r;
        alu_b   = AW'(brk_r);
        rd_addr = hdr_idx;
        cur_nxt = hdr_idx;
      end
      // Clear the allocated mark and link in front of the old head
      ST_FTEST: begin
        if (size_rd[0]) begin
          size_we    = 1'b1;
          size_waddr = cur_r;
          size_wdata = sz_clean;
          next_we    = 1'b1;
          next_waddr = cur_r;
          next_wdata = first_r;
          if (first_r != '0) begin
            prev_we    = 1'b1;
            prev_waddr = first_r;
            prev_wdata = cur_r;
          end else begin
            last_nxt   = cur_r;
          end
        end
      end
      // Finish the push: new head has no predecessor
      ST_FPUSH: begin
        prev_we    = 1'b1;
        prev_waddr = cur_r;
        prev_wdata = '0;
        first_nxt  = cur_r;
      end
      default: begin
      end
    endcase
  end

  // Configuration register
  assign lim_nxt = cfg_we ? cfg_wdata : lim_r;

  // Output register: hold until taken, reload from the result on completion
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_rsp.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      brk_r       <= BRK_W'(MINBLK);
      lim_r       <= HEAP_LIMIT_RST;
      first_r     <= '0;
      last_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      brk_r       <= brk_nxt;
      lim_r       <= lim_nxt;
      first_r     <= first_nxt;
      last_r      <= last_nxt;
    end
  end

  // Working registers and result payload
  always_ff @(posedge clk) begin
    req_r        <= req_nxt;
    fa_r         <= fa_nxt;
    need_r       <= need_nxt;
    sum_r        <= sum_nxt;
    cur_r        <= cur_nxt;
    steps_r      <= steps_nxt;
    res_addr_r   <= res_addr_nxt;
    res_status_r <= res_status_nxt;
    res_reused_r <= res_reused_nxt;
    res_bytes_r  <= res_bytes_nxt;
    if (out_load) begin
      out_addr_r   <= res_addr_r;
      out_status_r <= res_status_r;
      out_reused_r <= res_reused_r;
      out_bytes_r  <= res_bytes_r;
    end
  end

  assign in_req.ready        = (state_r == ST_IDLE);
  assign out_rsp.valid       = out_valid_r;
  assign out_rsp.addr        = out_addr_r;
  assign out_rsp.status      = out_status_r;
  assign out_rsp.reused      = out_reused_r;
  assign out_rsp.block_bytes = out_bytes_r;

`ifndef NO_ASSERTIONS
  // Head and tail of the free list are empty together, outside the push
  a_list_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_FPUSH) |-> ((first_r == '0) == (last_r == '0)))
    else $error("free list head and tail disagree on emptiness");

  // The break stays aligned and inside the heap
  a_brk_range: assert property (@(posedge clk) disable iff (!rst_n)
    (brk_r[SH-1:0] == '0) && (AW'(brk_r) <= AW'(HEAP_BYTES)))
    else $error("break pointer misaligned or beyond heap");

  // A new result beat only follows completion of a request
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_DONE))
    else $error("result raised without a completed request");

  // An out-of-memory result grants nothing
  a_oom_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == STATUS_OOM) |->
      (out_addr_r == '0 && out_bytes_r == '0 && !out_reused_r))
    else $error("out-of-memory result carries a grant");
`endif

endmodule
`default_nettype wire

// ===== rtl/ffa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module ffa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/ffa_alu.sv =====
// Shared adder/subtractor with unsigned greater-or-equal flag.
`default_nettype none
module ffa_alu import ffa_pkg::*; #(
  parameter int WIDTH = 18
) (
  input  wire ffa_alu_op_t             op,
  input  wire logic        [WIDTH-1:0] a,
  input  wire logic        [WIDTH-1:0] b,
  output logic             [WIDTH-1:0] res,
  output logic                         ge
);

  logic [WIDTH-1:0] b_eff;
  logic             cin;
  logic [WIDTH:0]   sum;

  // Select operand polarity and carry-in
  always_comb begin
    case (op)
      ALU_SUB: begin
        b_eff = ~b;
        cin   = 1'b1;
      end
      default: begin
        b_eff = b;
        cin   = 1'b0;
      end
    endcase
  end

  // One carry chain; carry out of a - b means a >= b
  assign sum = {1'b0, a} + {1'b0, b_eff} + {{WIDTH{1'b0}}, cin};
  assign res = sum[WIDTH-1:0];
  assign ge  = (op == ALU_SUB) ? sum[WIDTH] : 1'b0;

endmodule
`default_nettype wire
